// ===== rtl/jit_pkg.sv =====
`timescale 1ns / 1ps

package jit_pkg;

  // fixed field widths
  localparam int unsigned FuncW      = 3;
  localparam int unsigned JidW       = 5;
  localparam int unsigned StateW     = 2;

  // defaults for the top-level parameters
  localparam int unsigned DefDepth   = 16;
  localparam int unsigned DefPidBits = 22;

  // most results one list operation gives
  localparam int unsigned MaxResults = 16;

  // run state codes
  localparam logic [StateW-1:0] StForeground = 2'd1;
  localparam logic [StateW-1:0] StStopped    = 2'd3;

  // operation codes
  typedef enum logic [FuncW-1:0] {
    FnAdd     = 3'd0,
    FnDelete  = 3'd1,
    FnSuspend = 3'd2,
    FnFindPid = 3'd3,
    FnFindJid = 3'd4,
    FnFg      = 3'd5,
    FnClear   = 3'd6,
    FnList    = 3'd7
  } func_e;

  // which result the output register loads
  typedef enum logic [1:0] {
    EmitNone  = 2'd0,
    EmitMid   = 2'd1,
    EmitFinal = 2'd2
  } emit_e;

  // controller to datapath
  typedef struct packed {
    logic  load;       // capture the input item
    logic  scan_rst;   // restart the table scan
    logic  step;       // issue the next table read
    logic  take;       // act on the entry just read
    logic  set_nj;     // next job id from the rescan maximum
    logic  clear_tab;  // free every entry
    emit_e emit;
  } jit_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic is_list;
    logic is_del;
    logic key_bad;
    logic hit;
    logic scan_done;
    logic cnt_last;
    logic hold_v;
    logic out_free;
  } jit_sts_t;

endpackage

// ===== rtl/jit_dpath.sv =====
`timescale 1ns / 1ps

module jit_dpath #(
  parameter int unsigned DEPTH    = jit_pkg::DefDepth,
  parameter int unsigned PID_BITS = jit_pkg::DefPidBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  jit_pkg::jit_cmd_t           cmd_i,
  output jit_pkg::jit_sts_t           sts_o,
  input  logic [jit_pkg::FuncW-1:0]   func_i,
  input  logic [PID_BITS-1:0]         pid_i,
  input  logic [jit_pkg::JidW-1:0]    jid_i,
  input  logic [jit_pkg::StateW-1:0]  run_state_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        ok_o,
  output logic [PID_BITS-1:0]         pid_out_o,
  output logic [jit_pkg::JidW-1:0]    jid_out_o,
  output logic [jit_pkg::StateW-1:0]  state_out_o,
  output logic                        last_o
);

  import jit_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned NjMax = (DEPTH > 32) ? DEPTH : 32;
  localparam int unsigned NjW   = $clog2(NjMax + 2);
  localparam int unsigned ResW  = $clog2(MaxResults + 1);

  // captured item
  func_e              func_q;
  logic [PID_BITS-1:0] key_pid_q;
  logic [JidW-1:0]    key_jid_q;
  logic [StateW-1:0]  rs_q;

  // table storage, occupancy in flops
  logic [PID_BITS-1:0] mem_pid [DEPTH];
  logic [JidW-1:0]     mem_jid [DEPTH];
  logic [StateW-1:0]   mem_st  [DEPTH];
  logic [DEPTH-1:0]    valid_q;

  // scan read stage
  logic [CntW-1:0]     idx_q;
  logic [AddrW-1:0]    idx_addr;
  logic                issue;
  logic [PID_BITS-1:0] rd_pid_q;
  logic [JidW-1:0]     rd_jid_q;
  logic [StateW-1:0]   rd_st_q;
  logic [AddrW-1:0]    rd_idx_q;
  logic                rd_vld_q;
  logic                rd_live_q;

  // held result, rescan maximum, next job id
  logic [PID_BITS-1:0] hold_pid_q;
  logic [JidW-1:0]     hold_jid_q;
  logic [StateW-1:0]   hold_st_q;
  logic                hold_v_q;
  logic [ResW-1:0]     res_cnt_q;
  logic [JidW-1:0]     mx_q;
  logic [NjW-1:0]      nj_q;
  logic [NjW-1:0]      nj_wrap;

  // output register
  logic                out_valid_q;
  logic                ok_q;
  logic [PID_BITS-1:0] opid_q;
  logic [JidW-1:0]     ojid_q;
  logic [StateW-1:0]   ost_q;
  logic                last_q;

  // entry written by add or suspend
  logic                we;
  logic [PID_BITS-1:0] wr_pid;
  logic [JidW-1:0]     wr_jid;
  logic [StateW-1:0]   wr_st;
  logic                hit;
  logic                key_bad;

  assign idx_addr = idx_q[AddrW-1:0];
  assign issue    = cmd_i.step && (idx_q != CntW'(DEPTH));
  assign nj_wrap  = (nj_q >= NjW'(DEPTH)) ? NjW'(1) : nj_q + NjW'(1);

  // new entry contents
  always_comb begin
    we = cmd_i.take && ((func_q == FnAdd) || (func_q == FnSuspend));
    if (func_q == FnAdd) begin
      wr_pid = key_pid_q;
      wr_jid = nj_q[JidW-1:0];
      wr_st  = rs_q;
    end else begin
      wr_pid = rd_pid_q;
      wr_jid = rd_jid_q;
      wr_st  = StStopped;
    end
  end

  // match on the entry just read
  always_comb begin
    unique case (func_q)
      FnAdd:                          hit = !rd_vld_q;
      FnDelete, FnSuspend, FnFindPid: hit = rd_vld_q && (rd_pid_q == key_pid_q);
      FnFindJid:                      hit = rd_vld_q && (rd_jid_q == key_jid_q);
      FnFg:                           hit = rd_vld_q && (rd_st_q == StForeground);
      FnList:                         hit = rd_vld_q;
      default:                        hit = 1'b0;
    endcase
  end

  // zero keys are refused
  always_comb begin
    unique case (func_q)
      FnAdd, FnDelete, FnSuspend, FnFindPid: key_bad = (key_pid_q == '0);
      FnFindJid:                             key_bad = (key_jid_q == '0);
      default:                               key_bad = 1'b0;
    endcase
  end

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_pid[rd_idx_q] <= wr_pid;
      mem_jid[rd_idx_q] <= wr_jid;
      mem_st[rd_idx_q]  <= wr_st;
    end
    if (issue) begin
      rd_pid_q <= mem_pid[idx_addr];
      rd_jid_q <= mem_jid[idx_addr];
      rd_st_q  <= mem_st[idx_addr];
      rd_idx_q <= idx_addr;
      rd_vld_q <= valid_q[idx_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_live_q   <= 1'b0;
      valid_q     <= '0;
      hold_v_q    <= 1'b0;
      res_cnt_q   <= '0;
      nj_q        <= NjW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan_rst) begin
        idx_q     <= '0;
        rd_live_q <= 1'b0;
      end else if (cmd_i.step) begin
        rd_live_q <= issue;
        if (issue) begin
          idx_q <= idx_q + CntW'(1);
        end
      end
      if (cmd_i.clear_tab) begin
        valid_q <= '0;
      end else if (cmd_i.take && (func_q == FnAdd)) begin
        valid_q[rd_idx_q] <= 1'b1;
      end else if (cmd_i.take && (func_q == FnDelete)) begin
        valid_q[rd_idx_q] <= 1'b0;
      end
      if (cmd_i.load) begin
        hold_v_q  <= 1'b0;
        res_cnt_q <= '0;
      end else if (cmd_i.take) begin
        hold_v_q  <= 1'b1;
        res_cnt_q <= res_cnt_q + ResW'(1);
      end
      if (cmd_i.take && (func_q == FnAdd)) begin
        nj_q <= nj_wrap;
      end else if (cmd_i.set_nj) begin
        nj_q <= NjW'(mx_q) + NjW'(1);
      end
      if (cmd_i.emit != EmitNone) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q    <= func_e'(func_i);
      key_pid_q <= pid_i;
      key_jid_q <= jid_i;
      rs_q      <= run_state_i;
    end
    if (cmd_i.scan_rst) begin
      mx_q <= '0;
    end else if (cmd_i.step && rd_live_q && rd_vld_q && (rd_jid_q > mx_q)) begin
      mx_q <= rd_jid_q;
    end
    if (cmd_i.take) begin
      if (we) begin
        hold_pid_q <= wr_pid;
        hold_jid_q <= wr_jid;
        hold_st_q  <= wr_st;
      end else begin
        hold_pid_q <= rd_pid_q;
        hold_jid_q <= rd_jid_q;
        hold_st_q  <= rd_st_q;
      end
    end
    unique case (cmd_i.emit)
      EmitMid: begin
        ok_q   <= 1'b1;
        opid_q <= hold_pid_q;
        ojid_q <= hold_jid_q;
        ost_q  <= hold_st_q;
        last_q <= 1'b0;
      end
      EmitFinal: begin
        last_q <= 1'b1;
        if (func_q == FnClear) begin
          ok_q   <= 1'b1;
          opid_q <= '0;
          ojid_q <= '0;
          ost_q  <= '0;
        end else if (hold_v_q) begin
          ok_q   <= 1'b1;
          opid_q <= hold_pid_q;
          ojid_q <= hold_jid_q;
          ost_q  <= hold_st_q;
        end else begin
          ok_q   <= 1'b0;
          opid_q <= '0;
          ojid_q <= '0;
          ost_q  <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  assign sts_o.is_clear  = (func_q == FnClear);
  assign sts_o.is_list   = (func_q == FnList);
  assign sts_o.is_del    = (func_q == FnDelete);
  assign sts_o.key_bad   = key_bad;
  assign sts_o.hit       = rd_live_q && hit;
  assign sts_o.scan_done = (idx_q == CntW'(DEPTH)) && !rd_live_q;
  assign sts_o.cnt_last  = (res_cnt_q == ResW'(MaxResults - 1));
  assign sts_o.hold_v    = hold_v_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign pid_out_o   = opid_q;
  assign jid_out_o   = ojid_q;
  assign state_out_o = ost_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/jit_ctrl.sv =====
`timescale 1ns / 1ps

module jit_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jit_pkg::jit_sts_t sts_i,
  output jit_pkg::jit_cmd_t cmd_o
);

  import jit_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StScan,
    StRemax,
    StEmit
  } state_e;

  state_e state_q;
  state_e state_d;

  // sequencing of one item
  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == StIdle);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_rst = 1'b1;
          state_d        = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.is_clear) begin
          cmd_o.clear_tab = 1'b1;
          state_d         = StEmit;
        end else if (sts_i.key_bad) begin
          state_d = StEmit;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (sts_i.hit) begin
          if (sts_i.is_list) begin
            // a held entry goes out only once the next one is known
            if (!sts_i.hold_v || sts_i.out_free) begin
              cmd_o.take = 1'b1;
              cmd_o.step = 1'b1;
              if (sts_i.hold_v) begin
                cmd_o.emit = EmitMid;
              end
              if (sts_i.cnt_last) begin
                state_d = StEmit;
              end
            end
          end else begin
            cmd_o.take = 1'b1;
            if (sts_i.is_del) begin
              cmd_o.scan_rst = 1'b1;
              state_d        = StRemax;
            end else begin
              state_d = StEmit;
            end
          end
        end else if (sts_i.scan_done) begin
          state_d = StEmit;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StRemax: begin
        if (sts_i.scan_done) begin
          cmd_o.set_nj = 1'b1;
          state_d      = StEmit;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EmitFinal;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/job_id_table_top.sv =====
`timescale 1ns / 1ps
// Job table of DEPTH entries, each a process id, a job id and a run state.
// Input channel (in_valid_i / in_ready_o) takes one operation item: func_i,
// pid_i, jid_i and run_state_i. Output channel (out_valid_o / out_ready_i)
// returns result items: ok_o, pid_out_o, jid_out_o, state_out_o, last_o.
// Every operation gives one result item except list, which gives one per
// occupied entry (at most 16, or one failed item if none); last_o marks
// the final item of an operation. One operation is worked at a time. The
// table is a one-port memory scanned one entry per cycle through a
// registered read, unless list waits on a stalled receiver. Delete makes a
// second pass for the largest remaining job id; clear and a refused zero
// key skip the scan.
// The result sits in an output register; the next item is accepted while it
// waits. A stalled receiver holds the scan only where a new result item must
// be written; list keeps one found entry aside so it can mark the last one.
// Reset (rst_ni low, asynchronous) frees every entry through per-entry
// occupancy flops and sets the next job id to 1; no clearing pass is needed.
module job_id_table_top #(
  parameter int unsigned DEPTH    = jit_pkg::DefDepth,
  parameter int unsigned PID_BITS = jit_pkg::DefPidBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [jit_pkg::FuncW-1:0]   func_i,
  input  logic [PID_BITS-1:0]         pid_i,
  input  logic [jit_pkg::JidW-1:0]    jid_i,
  input  logic [jit_pkg::StateW-1:0]  run_state_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic [PID_BITS-1:0]         pid_out_o,
  output logic [jit_pkg::JidW-1:0]    jid_out_o,
  output logic [jit_pkg::StateW-1:0]  state_out_o,
  output logic                        last_o
);

  import jit_pkg::*;

  jit_cmd_t cmd;
  jit_sts_t sts;

  // sequencer
  jit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, scan stage and output register
  jit_dpath #(
    .DEPTH    (DEPTH),
    .PID_BITS (PID_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (func_i),
    .pid_i       (pid_i),
    .jid_i       (jid_i),
    .run_state_i (run_state_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .ok_o        (ok_o),
    .pid_out_o   (pid_out_o),
    .jid_out_o   (jid_out_o),
    .state_out_o (state_out_o),
    .last_o      (last_o)
  );

  // an accepted item keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again right after an item");

  // a result is never written over one still waiting
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit != EmitNone |-> sts.out_free)
    else $error("result item overwritten before it was taken");

  // an entry is only taken (written, freed or held) on a match
  a_take_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |-> sts.hit)
    else $error("entry taken without a match");

  // clear only for the clear operation
  a_clear_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_tab |-> sts.is_clear)
    else $error("table cleared by another operation");

endmodule
